### hw/rtl/next_fit_slot_allocator_refcount_core_defines.svh
// Assertion macros shared by the allocator's checker.
// No dependencies; include by bare file name.
`ifndef NEXT_FIT_SLOT_ALLOCATOR_REFCOUNT_CORE_DEFINES_SVH
`define NEXT_FIT_SLOT_ALLOCATOR_REFCOUNT_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NFSA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define NFSA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/nfsa_pkg.sv
// Package for the next-fit slot allocator: sizes, codes, item types
// and the free-slot search function. No dependencies.
`default_nettype none

package nfsa_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int REF_W     = 8;
    localparam int LOG2_W    = 3;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;

    localparam logic [LOG2_W-1:0] CFG_RESET = LOG2_W'(6);
    localparam logic [REF_W-1:0]  REF_MAX   = {REF_W{1'b1}};

    localparam logic [OP_W-1:0] OP_ATTACH = 2'd0;
    localparam logic [OP_W-1:0] OP_DETACH = 2'd1;
    localparam logic [OP_W-1:0] OP_RETAIN = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot_index;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot_out;
        logic [REF_W-1:0]  ref_after;
        logic [CNT_W-1:0]  free_after;
    } t_rsp;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } t_find;

    // size register clamped to the built pool
    function automatic logic [LOG2_W-1:0] pool_log2(input logic [LOG2_W-1:0] v);
        pool_log2 = (v > LOG2_W'(SLOT_W)) ? LOG2_W'(SLOT_W) : v;
    endfunction

    function automatic logic [CNT_W-1:0] pool_count(input logic [LOG2_W-1:0] k);
        pool_count = CNT_W'(1) << k;
    endfunction

    function automatic logic [SLOT_W-1:0] pool_mask(input logic [LOG2_W-1:0] k);
        logic [CNT_W-1:0] cnt;
        cnt       = pool_count(k) - CNT_W'(1);
        pool_mask = cnt[SLOT_W-1:0];
    endfunction

    // first free slot at or after the hint, else first free from slot zero
    function automatic t_find find_free(input logic [MAX_SLOTS-1:0] busy,
                                        input logic [SLOT_W-1:0]    hint,
                                        input logic [SLOT_W-1:0]    mask);
        logic [MAX_SLOTS-1:0] avail;
        logic [MAX_SLOTS-1:0] upper;
        logic [MAX_SLOTS-1:0] pick;
        logic [MAX_SLOTS-1:0] iso;
        t_find                res;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            avail[i] = !busy[i] && ((SLOT_W'(i) & ~mask) == '0);
            upper[i] = avail[i] && (SLOT_W'(i) >= hint);
        end
        pick      = (|upper) ? upper : avail;
        iso       = pick & (~pick + MAX_SLOTS'(1));
        res.found = |pick;
        res.idx   = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (iso[i]) begin
                res.idx = res.idx | SLOT_W'(i);
            end
        end
        find_free = res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/nfsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module nfsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/next_fit_slot_allocator_refcount_core.sv
// Next-fit slot allocator with per-slot reference counts (top level).
// Depends on nfsa_pkg and nfsa_ram.
//
// Each item takes two steps: at acceptance the slot's reference count is
// read from the count RAM into its registered output; in the execute state
// the in-use bitmap is searched from the hint, the count is modified and
// written back and the result register is loaded. The count RAM's
// registered read sets that split; a new item is taken while a result still
// waits to be collected, but the execute step holds until the result register is free. In-use
// marks live in flip-flops, so reset and a size write take effect at once
// with no clearing pass.
`default_nettype none

module next_fit_slot_allocator_refcount_core
    import nfsa_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [LOG2_W-1:0] i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_req              i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_rsp                   o_out_item
);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state               r_state;
    t_req                 r_req;
    logic [MAX_SLOTS-1:0] r_busy;
    logic [CNT_W-1:0]     r_free;
    logic [SLOT_W-1:0]    r_hint;
    logic [LOG2_W-1:0]    r_log2;
    logic                 r_out_valid;
    t_rsp                 r_out_item;

    logic [MAX_SLOTS-1:0] n_busy;
    logic [CNT_W-1:0]     n_free;
    logic [SLOT_W-1:0]    n_hint;
    t_rsp                 n_out_item;

    logic                 w_accept;
    logic                 w_commit;
    logic [LOG2_W-1:0]    w_k;
    logic [SLOT_W-1:0]    w_mask;
    logic                 w_target_ok;
    t_find                w_find;
    logic [REF_W-1:0]     w_ref_q;
    logic                 w_ram_we;
    logic [SLOT_W-1:0]    w_ram_waddr;
    logic [REF_W-1:0]     w_ram_wdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign w_accept = i_in_valid && o_in_ready;
    // the execute step completes only when the result register can take it
    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign w_k         = pool_log2(r_log2);
    assign w_mask      = pool_mask(w_k);
    assign w_target_ok = ((r_req.slot_index & ~w_mask) == '0) && r_busy[r_req.slot_index];
    assign w_find      = find_free(r_busy, r_hint, w_mask);

    nfsa_ram #(
        .WIDTH (REF_W),
        .DEPTH (MAX_SLOTS)
    ) u_refs (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (i_in_item.slot_index),
        .o_rdata (w_ref_q)
    );

    always_comb begin
        n_busy      = r_busy;
        n_free      = r_free;
        n_hint      = r_hint;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_req.slot_index;
        w_ram_wdata = w_ref_q;

        n_out_item.status     = ST_IGNORED;
        n_out_item.slot_out   = r_req.slot_index;
        n_out_item.ref_after  = '0;
        n_out_item.free_after = r_free;

        case (r_req.op) inside
            OP_ATTACH: begin
                if (w_find.found) begin
                    n_busy[w_find.idx] = 1'b1;
                    n_free             = r_free - CNT_W'(1);
                    n_hint             = (w_find.idx + SLOT_W'(1)) & w_mask;
                    w_ram_we           = w_commit;
                    w_ram_waddr        = w_find.idx;
                    w_ram_wdata        = REF_W'(1);
                    n_out_item.status     = ST_DONE;
                    n_out_item.slot_out   = w_find.idx;
                    n_out_item.ref_after  = REF_W'(1);
                    n_out_item.free_after = n_free;
                end else begin
                    n_out_item.status   = ST_FULL;
                    n_out_item.slot_out = '0;
                end
            end
            OP_DETACH, OP_RETAIN: begin
                if (w_target_ok) begin
                    w_ram_we = w_commit;
                    if (r_req.op == OP_RETAIN) begin
                        // saturates at the top of the count
                        w_ram_wdata = (w_ref_q == REF_MAX) ? w_ref_q : w_ref_q + REF_W'(1);
                    end else if (w_ref_q > REF_W'(1)) begin
                        w_ram_wdata = w_ref_q - REF_W'(1);
                    end else begin
                        // last reference gone: slot returns to the pool
                        w_ram_wdata              = '0;
                        n_busy[r_req.slot_index] = 1'b0;
                        n_free                   = r_free + CNT_W'(1);
                        n_hint                   = r_req.slot_index;
                    end
                    n_out_item.status     = ST_DONE;
                    n_out_item.ref_after  = w_ram_wdata;
                    n_out_item.free_after = n_free;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_busy      <= '0;
            r_free      <= pool_count(pool_log2(CFG_RESET));
            r_hint      <= '0;
            r_log2      <= CFG_RESET;
        end else begin
            if (i_cfg_we) begin
                r_log2 <= i_cfg_wdata;
                r_busy <= '0;
                r_free <= pool_count(pool_log2(i_cfg_wdata));
                r_hint <= '0;
            end else if (w_commit) begin
                r_busy <= n_busy;
                r_free <= n_free;
                r_hint <= n_hint;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req   <= i_in_item;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_out_item  <= n_out_item;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/nfsa_chk.sv
// Port-level checker for the slot allocator, bound to the top level.
// Depends on nfsa_pkg and the assertion macro header.
`default_nettype none
`include "next_fit_slot_allocator_refcount_core_defines.svh"

module nfsa_chk
    import nfsa_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_cfg_we,
    input wire logic [LOG2_W-1:0] i_cfg_wdata,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire t_req              i_in_item,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire t_rsp              o_out_item
);

    logic w_in_acc;
    logic w_full;
    logic w_ignored;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_full    = o_out_valid && (o_out_item.status == ST_FULL);
    assign w_ignored = o_out_valid && (o_out_item.status == ST_IGNORED);

    // once an item is accepted, ready drops while it is worked on
    `NFSA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_in_acc, !o_in_ready, "ready after accept")
    // a pending result holds until taken
    `NFSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result dropped")
    // pool full only with no free slots and no references reported
    `NFSA_ASSERT_NOW(a_full_empty, i_clk, i_rst_n, w_full, (o_out_item.free_after == '0) && (o_out_item.ref_after == '0), "full with free slots")
    // an ignored request reports no references
    `NFSA_ASSERT_NOW(a_ignored_ref, i_clk, i_rst_n, w_ignored, o_out_item.ref_after == '0, "ignored with refs")

endmodule

bind next_fit_slot_allocator_refcount_core nfsa_chk u_nfsa_chk (.*);

`default_nettype wire

### tb/next_fit_slot_allocator_refcount_core_test.sv
// Testbench for next_fit_slot_allocator_refcount_core: directed and random
// attach/detach/retain items checked against a behavioural pool model.
// Depends on nfsa_pkg and the allocator RTL.
`default_nettype none

module next_fit_slot_allocator_refcount_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nfsa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STIM_COPY   = 0;   // pool as the generator expects it
    localparam int DUT_COPY    = 1;   // pool as items are accepted
    localparam int HOLD_CYCLES = 150;
    localparam int LIMIT       = 400000;
    localparam int MAX_LINES   = 200;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [LOG2_W-1:0] i_cfg_wdata = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_req              i_in_item   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_rsp              o_out_item;

    // two copies of the pool state
    logic [MAX_SLOTS-1:0] slot_busy [2];
    logic [REF_W-1:0]     slot_refs [2][MAX_SLOTS];
    int unsigned          free_cnt  [2];
    int unsigned          hint      [2];
    int unsigned          pool_slots[2];

    t_req  pending_reqs[$];
    t_rsp  predicted_rsps[$];
    t_idle idle_mode    = IDLE_NONE;
    int    useful_items = 0;
    int    mismatches   = 0;
    int    cycles       = 0;
    int    holds_asked  = 0;
    int    holds_served = 0;
    int    hold_left    = 0;

    next_fit_slot_allocator_refcount_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void pool_reset(input int c, input logic [LOG2_W-1:0] log2_size);
        int unsigned k;
        k = (log2_size > SLOT_W) ? SLOT_W : log2_size;
        pool_slots[c] = 1 << k;
        slot_busy[c]  = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            slot_refs[c][i] = '0;
        end
        free_cnt[c] = pool_slots[c];
        hint[c]     = 0;
    endfunction

    // one allocator step on copy c: next-fit attach, counted detach/retain
    function automatic t_rsp pool_apply(input int c, input t_req r);
        t_rsp        rsp;
        int unsigned size;
        int unsigned s;
        int unsigned slot;
        logic        found;
        size         = pool_slots[c];
        slot         = r.slot_index;
        rsp.status   = ST_IGNORED;
        rsp.slot_out = r.slot_index;
        rsp.ref_after = '0;
        if (r.op == OP_ATTACH) begin
            rsp.status   = ST_FULL;
            rsp.slot_out = '0;
            found        = 1'b0;
            if (free_cnt[c] != 0) begin
                for (int i = 0; i < size; i++) begin
                    s = (hint[c] + i) % size;
                    if (!found && !slot_busy[c][s]) begin
                        found            = 1'b1;
                        slot_busy[c][s]  = 1'b1;
                        slot_refs[c][s]  = 8'd1;
                        free_cnt[c]      = free_cnt[c] - 1;
                        hint[c]          = (s + 1) % size;
                        rsp.status       = ST_DONE;
                        rsp.slot_out     = SLOT_W'(s);
                        rsp.ref_after    = 8'd1;
                    end
                end
            end
        end else if ((r.op == OP_DETACH || r.op == OP_RETAIN) && slot < size
                     && slot_busy[c][slot]) begin
            rsp.status = ST_DONE;
            if (r.op == OP_DETACH) begin
                if (slot_refs[c][slot] > 1) begin
                    slot_refs[c][slot] = slot_refs[c][slot] - 1;
                end else begin
                    slot_busy[c][slot] = 1'b0;
                    slot_refs[c][slot] = '0;
                    free_cnt[c]        = free_cnt[c] + 1;
                    hint[c]            = slot;
                end
            end else if (slot_refs[c][slot] != REF_MAX) begin
                slot_refs[c][slot] = slot_refs[c][slot] + 1;
            end
            rsp.ref_after = slot_refs[c][slot];
        end
        rsp.free_after = CNT_W'(free_cnt[c]);
        return rsp;
    endfunction

    function automatic void push_req(input logic [OP_W-1:0] op, input int slot);
        t_req r;
        t_rsp planned;
        r.op         = op;
        r.slot_index = SLOT_W'(slot);
        planned      = pool_apply(STIM_COPY, r);
        if (planned.status != ST_IGNORED) begin
            useful_items++;
        end
        pending_reqs.push_back(r);
    endfunction

    function automatic int pick_busy();
        int unsigned size;
        int unsigned start;
        int unsigned s;
        size  = pool_slots[STIM_COPY];
        start = $urandom_range(0, size - 1);
        for (int i = 0; i < size; i++) begin
            s = (start + i) % size;
            if (slot_busy[STIM_COPY][s]) begin
                return s;
            end
        end
        return -1;
    endfunction

    function automatic int rand_slot();
        int b;
        int r;
        b = pick_busy();
        r = $urandom_range(0, 99);
        if (r < 75 && b >= 0) begin
            return b;
        end else if (r < 88) begin
            return $urandom_range(0, pool_slots[STIM_COPY] - 1);
        end
        return $urandom_range(0, MAX_SLOTS - 1);
    endfunction

    function automatic void retain_run(input int len);
        int b;
        b = pick_busy();
        if (b < 0) begin
            push_req(OP_ATTACH, $urandom_range(0, MAX_SLOTS - 1));
            b = pick_busy();
        end
        if (b >= 0) begin
            for (int i = 0; i < len; i++) begin
                push_req(OP_RETAIN, b);
            end
            for (int i = $urandom_range(1, 3); i > 0; i--) begin
                push_req(OP_DETACH, b);
            end
        end
    endfunction

    function automatic void random_burst();
        int kind;
        int n;
        int r;
        int b;
        kind = $urandom_range(0, 9);
        case (kind)
            3: begin
                // fill to full and knock once or twice more
                n = free_cnt[STIM_COPY] + $urandom_range(1, 2);
                for (int i = 0; i < n; i++) begin
                    push_req(OP_ATTACH, $urandom_range(0, MAX_SLOTS - 1));
                end
            end
            4: begin
                n = $urandom_range(1, 20);
                for (int i = 0; i < n; i++) begin
                    b = pick_busy();
                    if (b >= 0) begin
                        push_req(OP_DETACH, b);
                    end
                end
            end
            5: begin
                retain_run(($urandom_range(0, 7) == 0) ? 260 : $urandom_range(1, 6));
            end
            6: begin
                // noise: undefined op, detach or retain on random slots
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) begin
                    r = $urandom_range(0, 2);
                    if (r == 0) begin
                        push_req(OP_UNUSED, $urandom_range(0, MAX_SLOTS - 1));
                    end else begin
                        push_req((r == 1) ? OP_DETACH : OP_RETAIN,
                                 $urandom_range(0, MAX_SLOTS - 1));
                    end
                end
            end
            default: begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 35) begin
                        push_req(OP_ATTACH, $urandom_range(0, MAX_SLOTS - 1));
                    end else if (r < 65) begin
                        push_req(OP_DETACH, rand_slot());
                    end else if (r < 95) begin
                        push_req(OP_RETAIN, rand_slot());
                    end else begin
                        push_req(OP_UNUSED, rand_slot());
                    end
                end
            end
        endcase
    endfunction

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SEND: return 47;
            IDLE_BOTH: return 32;
            default:   return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (idle_mode)
            IDLE_RECV: return 47;
            IDLE_BOTH: return 32;
            default:   return 0;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_LINES) begin
            $display("cycle %0d: %s", cycles, msg);
        end
    endtask

    // sampled away from the rising edge, after the driver's updates settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || predicted_rsps.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_pool_log2(input logic [LOG2_W-1:0] v);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pool_reset(DUT_COPY, v);
        pool_reset(STIM_COPY, v);
    endtask

    task automatic run_phase(input logic [LOG2_W-1:0] v, input t_idle mode, input int n,
                             input logic hold);
        set_pool_log2(v);
        @(negedge i_clk);
        idle_mode = mode;
        if (hold) begin
            holds_asked++;
        end
        useful_items = 0;
        while (useful_items < n) begin
            random_burst();
        end
    endtask

    // driver: predicts on acceptance, then offers the next pending item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predicted_rsps.push_back(pool_apply(DUT_COPY, i_in_item));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    i_in_item  <= pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (holds_asked != holds_served) begin
            i_out_ready  <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct());
        end
    end

    always @(posedge i_clk) begin : result_check
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_rsps.size() == 0) begin
                report_mismatch($sformatf("unexpected item, slot_out %0d",
                                          o_out_item.slot_out));
            end else begin
                want = predicted_rsps.pop_front();
                if (o_out_item.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_out_item.status, want.status));
                if (o_out_item.slot_out !== want.slot_out)
                    report_mismatch($sformatf("slot_out %0d, want %0d",
                                              o_out_item.slot_out, want.slot_out));
                if (o_out_item.ref_after !== want.ref_after)
                    report_mismatch($sformatf("ref_after %0d, want %0d",
                                              o_out_item.ref_after, want.ref_after));
                if (o_out_item.free_after !== want.free_after)
                    report_mismatch($sformatf("free_after %0d, want %0d",
                                              o_out_item.free_after, want.free_after));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        pool_reset(STIM_COPY, CFG_RESET);
        pool_reset(DUT_COPY, CFG_RESET);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full-size pool out of reset: free slots, undefined op, refcounts
        push_req(OP_DETACH, 0);
        push_req(OP_RETAIN, 63);
        push_req(OP_UNUSED, 63);
        push_req(OP_ATTACH, 63);
        push_req(OP_ATTACH, 0);
        push_req(OP_ATTACH, 0);
        push_req(OP_RETAIN, 1);
        push_req(OP_RETAIN, 1);
        push_req(OP_DETACH, 1);
        push_req(OP_DETACH, 1);
        push_req(OP_DETACH, 1);   // last reference, hint returns to 1
        push_req(OP_ATTACH, 0);
        push_req(OP_DETACH, 0);
        push_req(OP_ATTACH, 0);
        push_req(OP_DETACH, 63);
        push_req(OP_RETAIN, 2);

        // single-slot pool: full, out of range
        set_pool_log2(3'd0);
        push_req(OP_ATTACH, 0);
        push_req(OP_ATTACH, 0);
        push_req(OP_RETAIN, 0);
        push_req(OP_DETACH, 5);
        push_req(OP_RETAIN, 63);
        push_req(OP_DETACH, 0);
        push_req(OP_DETACH, 0);
        push_req(OP_ATTACH, 0);

        run_phase(3'd1, IDLE_NONE, 100, 1'b0);
        retain_run(260);   // push a count into saturation
        run_phase(3'd7, IDLE_SEND, 140, 1'b0);
        run_phase(3'd2, IDLE_RECV, 110, 1'b0);
        run_phase(3'd6, IDLE_BOTH, 140, 1'b0);
        run_phase(3'd0, IDLE_SEND, 50,  1'b0);
        run_phase(3'd3, IDLE_RECV, 110, 1'b1);
        run_phase(3'd4, IDLE_BOTH, 110, 1'b0);
        run_phase(3'd5, IDLE_NONE, 100, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (predicted_rsps.size() != 0) begin
            report_mismatch($sformatf("%0d items never returned", predicted_rsps.size()));
        end
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/nfsa_pkg.sv
hw/rtl/nfsa_ram.sv
hw/rtl/next_fit_slot_allocator_refcount_core.sv
hw/rtl/nfsa_chk.sv
tb/next_fit_slot_allocator_refcount_core_test.sv
